// File: rtl/gha_pkg.sv
// Package for the generational handle allocator: sizes, operation codes,
// transaction payload types and the slot table row layout.
// Used by gha_controller, gha_datapath and generational_handle_allocator.
package gha_pkg;

   localparam int SLOTS     = 1024;
   localparam int GEN_BITS  = 16;
   localparam int TAG_BITS  = 32;
   localparam int IDX_BITS  = $clog2(SLOTS);
   localparam int LINK_BITS = $clog2(SLOTS + 1);
   localparam int MODE_BITS = 3;

   // The link value one past the last slot marks the end of the free list.
   localparam logic [LINK_BITS-1:0] NONE_LINK = LINK_BITS'(SLOTS);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_RESERVE = 3'd0,
      MODE_FREE    = 3'd1,
      MODE_BIND    = 3'd2,
      MODE_REMOVE  = 3'd3,
      MODE_CHECK   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [9:0]           slot_index;
      logic [GEN_BITS-1:0]  generation;
      logic [TAG_BITS-1:0]  object_tag;
      logic                 release_req;
   } req_type;

   typedef struct packed {
      logic                 accepted;
      logic [9:0]           out_index;
      logic [GEN_BITS-1:0]  out_generation;
      logic [TAG_BITS-1:0]  out_tag;
      logic                 is_reserved;
      logic                 is_bound;
      logic [LINK_BITS-1:0] bound_count;
   } rsp_type;

   typedef struct packed {
      logic [GEN_BITS-1:0]  gen;
      logic                 reserved;
      logic                 bound;
      logic [TAG_BITS-1:0]  tag;
      logic [LINK_BITS-1:0] link;
   } row_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// File: rtl/generational_handle_allocator.sv
// Each transaction reads the addressed slot row from the single-port slot table
// (the free list head for reserve), then updates it, writes it back and loads the
// response register. A new request is taken while an earlier response still waits
// in that register. The table needs no clearing pass after reset: a fill mark
// tracks which slots have ever been reserved, and rows at or above it read as
// their reset contents.
// Depends on gha_pkg, gha_controller and gha_datapath.
module generational_handle_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gha_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gha_pkg::rsp_type  rsp_data
);

   gha_pkg::cmd_type cmd;

   gha_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gha_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Only one transaction is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in work");

   a_bound_is_reserved: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_bound) |-> (rsp_data.is_reserved && rsp_data.accepted))
      else $error("bound handle reported without reservation");

   a_tag_only_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_bound) |-> (rsp_data.out_tag == '0))
      else $error("tag returned for an unbound handle");

   a_bound_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.bound_count) <= gha_pkg::SLOTS))
      else $error("bound count above table size");

endmodule

// File: rtl/gha_controller.sv
// Controller of the generational handle allocator: sequences the read and
// write-back cycles of one transaction and owns the response valid flag.
// Depends on gha_pkg.
module gha_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gha_pkg::cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit  = (state_ff == S_EXEC) && out_free;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // The write-back waits until the output register can take the result.
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/gha_datapath.sv
// Datapath of the generational handle allocator: slot table memory, free
// list head, fill mark, bound counter and the response register.
// Depends on gha_pkg; driven by commands from gha_controller.
module gha_datapath (
   input  logic              clock,
   input  logic              reset,
   input  gha_pkg::cmd_type  cmd,
   input  gha_pkg::req_type  req_data,
   output gha_pkg::rsp_type  rsp_data
);

   localparam logic [gha_pkg::GEN_BITS-1:0] GEN_NEVER = '1;

   gha_pkg::row_type                   mem [gha_pkg::SLOTS];
   gha_pkg::row_type                   rd_row_ff;
   gha_pkg::req_type                   req_ff;
   logic [gha_pkg::IDX_BITS-1:0]       addr_ff, addr_in;
   logic                               in_range_ff;
   logic [gha_pkg::LINK_BITS-1:0]      head_ff, head_in;
   logic [gha_pkg::LINK_BITS-1:0]      fresh_ff, fresh_in;
   logic [gha_pkg::LINK_BITS-1:0]      bound_ff, bound_in;
   gha_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                               live;
   logic [gha_pkg::GEN_BITS-1:0]       cur_gen, next_gen;
   logic                               cur_res, cur_bnd, match;
   logic [gha_pkg::LINK_BITS-1:0]      cur_link, addr_link;
   gha_pkg::row_type                   wr_row;
   logic                               wr_en;

   assign addr_in = (req_data.mode == gha_pkg::MODE_RESERVE) ?
                    head_ff[gha_pkg::IDX_BITS-1:0] :
                    req_data.slot_index[gha_pkg::IDX_BITS-1:0];

   // Slots at or above the fill mark were never reserved: their row is not
   // stored yet and reads as the reset contents, linked to the next slot.
   assign addr_link = gha_pkg::LINK_BITS'({1'b0, addr_ff}) + gha_pkg::LINK_BITS'(1);
   assign live      = gha_pkg::LINK_BITS'({1'b0, addr_ff}) < fresh_ff;
   assign cur_gen   = live ? rd_row_ff.gen : GEN_NEVER;
   assign cur_res   = live && rd_row_ff.reserved;
   assign cur_bnd   = live && rd_row_ff.bound;
   assign cur_link  = live ? rd_row_ff.link : addr_link;
   assign match     = (req_ff.generation != GEN_NEVER) && in_range_ff && cur_res &&
                      (cur_gen == req_ff.generation);

   always_comb begin
      next_gen = cur_gen + gha_pkg::GEN_BITS'(1);
      if (next_gen == GEN_NEVER) begin
         next_gen = '0;
      end
   end

   always_comb begin
      head_in  = head_ff;
      fresh_in = fresh_ff;
      bound_in = bound_ff;
      wr_en    = 1'b0;
      wr_row   = rd_row_ff;
      wr_row.gen = cur_gen;
      wr_row.reserved = cur_res;
      wr_row.bound = cur_bnd;
      wr_row.link = cur_link;
      rsp_in   = '0;
      case (req_ff.mode)
         gha_pkg::MODE_RESERVE: begin
            if (head_ff != gha_pkg::NONE_LINK) begin
               wr_en           = 1'b1;
               wr_row.gen      = next_gen;
               wr_row.reserved = 1'b1;
               wr_row.bound    = 1'b0;
               wr_row.link     = gha_pkg::NONE_LINK;
               head_in         = cur_link;
               if (!live) begin
                  fresh_in = addr_link;
               end
               rsp_in.accepted       = 1'b1;
               rsp_in.out_index      = 10'(addr_ff);
               rsp_in.out_generation = next_gen;
            end
         end
         gha_pkg::MODE_FREE: begin
            if (match) begin
               wr_en           = 1'b1;
               wr_row.reserved = 1'b0;
               wr_row.bound    = 1'b0;
               wr_row.link     = head_ff;
               head_in         = gha_pkg::LINK_BITS'({1'b0, addr_ff});
               if (cur_bnd) begin
                  bound_in = bound_ff - gha_pkg::LINK_BITS'(1);
               end
               rsp_in.accepted = 1'b1;
            end
         end
         gha_pkg::MODE_BIND: begin
            if (match && !cur_bnd) begin
               wr_en           = 1'b1;
               wr_row.bound    = 1'b1;
               wr_row.tag      = req_ff.object_tag;
               bound_in        = bound_ff + gha_pkg::LINK_BITS'(1);
               rsp_in.accepted = 1'b1;
            end
         end
         gha_pkg::MODE_REMOVE: begin
            if (match && cur_bnd) begin
               wr_en        = 1'b1;
               wr_row.bound = 1'b0;
               bound_in     = bound_ff - gha_pkg::LINK_BITS'(1);
               if (req_ff.release_req) begin
                  wr_row.reserved = 1'b0;
                  wr_row.link     = head_ff;
                  head_in         = gha_pkg::LINK_BITS'({1'b0, addr_ff});
               end
               rsp_in.accepted = 1'b1;
            end
         end
         gha_pkg::MODE_CHECK: begin
            rsp_in.accepted    = 1'b1;
            rsp_in.is_reserved = match;
            rsp_in.is_bound    = match && cur_bnd;
            if (match && cur_bnd) begin
               rsp_in.out_tag = rd_row_ff.tag;
            end
         end
         default: begin
         end
      endcase
      rsp_in.bound_count = bound_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_row_ff <= mem[addr_in];
      end
      if (cmd.commit && wr_en) begin
         mem[addr_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         addr_ff     <= addr_in;
         in_range_ff <= 32'(req_data.slot_index) < gha_pkg::SLOTS;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         fresh_ff <= '0;
         bound_ff <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
         bound_ff <= bound_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
